@@ hw/rtl/tck_pkg.sv @@
package tck_pkg;

    localparam int TICK_W = 64;
    localparam int MS_W   = 32;
    localparam int CNT_W  = $clog2(TICK_W);

    localparam logic [MS_W-1:0] TICKS_PER_MS_RESET = 32'd100000;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE = 3'd0;
    localparam logic [ST_W-1:0] S_DIV  = 3'd1;
    localparam logic [ST_W-1:0] S_MUL  = 3'd2;
    localparam logic [ST_W-1:0] S_UPD  = 3'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hw/rtl/tick_to_millisecond_converter_top.sv @@
// channel | direction | handshake                          | payload
// s_axis  | in        | i_s_axis_tvalid / o_s_axis_tready  | tick_now [63:0]
// m_axis  | out       | o_m_axis_tvalid / i_m_axis_tready  | elapsed_ms [31:0]
// cfg     | in        | i_cfg_wr_en                        | ticks_per_ms [31:0]
//
// from accept to result a sample passes through 64 steps of the bit-serial divider,
// the quotient capture, the 32x32 product and the update
// a new sample can be accepted from the cycle after its result is loaded into the output register
// synchronous active-low reset clears ticks_per_ms to 100000, base tick and count to zero
// a stalled output holds the update step until the previous result is taken
module tick_to_millisecond_converter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [63:0]                 i_s_axis_tdata,   // [63:0] tick_now
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [31:0]                 o_m_axis_tdata,   // [31:0] elapsed_ms
    input  logic                        i_cfg_wr_en,
    input  logic [31:0]                 i_cfg_wr_data
);

    logic [tck_pkg::ST_W-1:0]   r_state, n_state;
    logic [tck_pkg::MS_W-1:0]   r_tpm;
    logic [tck_pkg::TICK_W-1:0] r_base;
    logic [tck_pkg::MS_W-1:0]   r_ms;
    logic [tck_pkg::MS_W-1:0]   r_q;
    logic [tck_pkg::TICK_W-1:0] r_prod;
    logic                       r_out_valid;
    logic [tck_pkg::MS_W-1:0]   r_out_data;

    logic                       w_in_xfer;
    logic                       w_out_free;
    logic [tck_pkg::TICK_W-1:0] w_span;
    logic [tck_pkg::TICK_W-1:0] w_prod;
    logic [tck_pkg::MS_W-1:0]   w_quot;
    tck_pkg::t_div_stat         w_div_stat;

    assign o_s_axis_tready = (r_state == tck_pkg::S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_span          = i_s_axis_tdata - r_base;
    assign w_prod          = tck_pkg::TICK_W'(r_q) * tck_pkg::TICK_W'(r_tpm);

    tck_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_xfer),
        .i_dividend (w_span),
        .i_divisor  (r_tpm),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            tck_pkg::S_IDLE: begin
                if (w_in_xfer) n_state = tck_pkg::S_DIV;
            end
            tck_pkg::S_DIV: begin
                if (w_div_stat.done) n_state = tck_pkg::S_MUL;
            end
            tck_pkg::S_MUL: begin
                n_state = tck_pkg::S_UPD;
            end
            tck_pkg::S_UPD: begin
                if (w_out_free) n_state = tck_pkg::S_IDLE;
            end
            default: begin
                n_state = tck_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tck_pkg::S_IDLE;
            r_tpm       <= tck_pkg::TICKS_PER_MS_RESET;
            r_base      <= '0;
            r_ms        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_tpm <= i_cfg_wr_data;
            if (r_out_valid && i_m_axis_tready) r_out_valid <= 1'b0;
            if (r_state == tck_pkg::S_UPD && w_out_free) begin
                r_base      <= r_base + r_prod;
                r_ms        <= r_ms + r_q;
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tck_pkg::S_DIV && w_div_stat.done) begin
            // zero divisor gives a zero quotient
            r_q <= (r_tpm == '0) ? '0 : w_quot;
        end
        if (r_state == tck_pkg::S_MUL) r_prod <= w_prod;
        if (r_state == tck_pkg::S_UPD && w_out_free) r_out_data <= r_ms + r_q;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_out_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == tck_pkg::S_UPD)
        else $error("result raised outside update step");

    a_ms_only_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_ms) |-> $past(r_state) == tck_pkg::S_UPD)
        else $error("millisecond count changed outside update step");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == tck_pkg::S_DIV)
        else $error("divider finished while sequencer not waiting");

endmodule

@@ hw/rtl/tck_div.sv @@
module tck_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tck_pkg::TICK_W-1:0]    i_dividend,
    input  logic [tck_pkg::MS_W-1:0]      i_divisor,
    output tck_pkg::t_div_stat            o_stat,
    output logic [tck_pkg::MS_W-1:0]      o_quot
);

    logic [tck_pkg::TICK_W-1:0] r_acc, n_acc;
    logic [tck_pkg::MS_W-1:0]   r_rem, n_rem;
    logic [tck_pkg::MS_W-1:0]   r_dvs;
    logic [tck_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [tck_pkg::MS_W:0]     w_shift;
    logic [tck_pkg::MS_W:0]     w_diff;
    logic                       w_ge;

    // one restoring step: shift in next dividend bit, compare and subtract
    assign w_shift = {r_rem, r_acc[tck_pkg::TICK_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_comb begin
        n_rem = w_ge ? w_diff[tck_pkg::MS_W-1:0] : w_shift[tck_pkg::MS_W-1:0];
        n_acc = {r_acc[tck_pkg::TICK_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tck_pkg::CNT_W'(tck_pkg::TICK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_acc[tck_pkg::MS_W-1:0];

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done together");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && $past(r_cnt) == tck_pkg::CNT_W'(tck_pkg::TICK_W - 1))
        else $error("divider done without final step");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(r_busy) && $past(i_rst_n) |-> r_cnt == '0)
        else $error("divider started with nonzero count");

endmodule

@@ dv/testbench.sv @@
module testbench;

    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_SAMPLES = 1650;

    typedef enum logic [1:0] {
        FEED_SAMPLE,
        FEED_RATE,
        FEED_DRAIN
    } t_feed_op;

    typedef struct {
        t_feed_op                   op;
        logic [tck_pkg::TICK_W-1:0] value;
    } t_feed_entry;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       s_valid = 1'b0;
    logic [tck_pkg::TICK_W-1:0] s_data = '0;
    logic                       m_ready = 1'b0;
    logic                       cfg_wr = 1'b0;
    logic [tck_pkg::MS_W-1:0]   cfg_data = '0;
    logic                       o_s_axis_tready;
    logic                       o_m_axis_tvalid;
    logic [tck_pkg::MS_W-1:0]   o_m_axis_tdata;

    t_feed_entry                tick_feed[$];
    logic [tck_pkg::MS_W-1:0]   ms_due[$];

    // predictor state
    logic [tck_pkg::MS_W-1:0]   rate_model = tck_pkg::TICKS_PER_MS_RESET;
    logic [tck_pkg::TICK_W-1:0] base_model = '0;
    logic [tck_pkg::MS_W-1:0]   total_model = '0;

    int                samples_sent = 0;
    int                results_seen = 0;
    int                rate_writes = 0;
    int                mismatch_count = 0;
    int                quiet_cycles = 0;
    int                total_samples = 0;
    bit                feed_done = 1'b0;

    tick_to_millisecond_converter_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (cfg_wr),
        .i_cfg_wr_data   (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [tck_pkg::MS_W-1:0] project_ms_count(
        logic [tck_pkg::TICK_W-1:0] tick_now);
        logic [tck_pkg::TICK_W-1:0] span;
        logic [tck_pkg::TICK_W-1:0] quot;
        logic [tck_pkg::MS_W-1:0]   q;
        span = tick_now - base_model;
        q = '0;
        if (rate_model != 0) begin
            quot = span / {32'd0, rate_model};
            q = quot[tck_pkg::MS_W-1:0];
        end
        total_model = total_model + q;
        base_model = base_model + {32'd0, q} * {32'd0, rate_model};
        return total_model;
    endfunction

    task automatic queue_sample(logic [tck_pkg::TICK_W-1:0] v);
        t_feed_entry e;
        e.op = FEED_SAMPLE;
        e.value = v;
        tick_feed.push_back(e);
        total_samples++;
    endtask

    task automatic queue_rate(logic [tck_pkg::MS_W-1:0] v);
        t_feed_entry e;
        e.op = FEED_RATE;
        e.value = {32'd0, v};
        tick_feed.push_back(e);
    endtask

    task automatic queue_drain();
        t_feed_entry e;
        e.op = FEED_DRAIN;
        e.value = '0;
        tick_feed.push_back(e);
    endtask

    // driver
    always @(posedge i_clk) begin
        logic                       fire;
        logic                       nxt_valid;
        logic [tck_pkg::TICK_W-1:0] nxt_data;
        logic                       nxt_wr;
        logic [tck_pkg::MS_W-1:0]   nxt_wdata;
        int                         third;
        int                         gap_pct;
        if (i_rst_n) begin
            third = total_samples / 3;
            gap_pct = (samples_sent < third) ? 27 : (samples_sent < 2 * third) ? 84 : 0;
            fire = s_valid && o_s_axis_tready;
            nxt_valid = s_valid;
            nxt_data = s_data;
            nxt_wr = 1'b0;
            nxt_wdata = cfg_data;
            if (fire) begin
                ms_due.push_back(project_ms_count(s_data));
                samples_sent++;
                nxt_valid = 1'b0;
            end
            if (ms_due.size() == 0 && !s_valid && !cfg_wr)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nxt_valid && tick_feed.size() > 0) begin
                case (tick_feed[0].op)
                    FEED_SAMPLE: begin
                        if ($urandom_range(0, 99) >= gap_pct) begin
                            nxt_valid = 1'b1;
                            nxt_data = tick_feed[0].value;
                            void'(tick_feed.pop_front());
                        end
                    end
                    FEED_RATE: begin
                        // only write while the block is idle
                        if (!fire && quiet_cycles >= SETTLE_CYCLES) begin
                            nxt_wr = 1'b1;
                            nxt_wdata = tick_feed[0].value[tck_pkg::MS_W-1:0];
                            rate_model = nxt_wdata;
                            rate_writes++;
                            quiet_cycles = 0;
                            void'(tick_feed.pop_front());
                        end
                    end
                    FEED_DRAIN: begin
                        if (ms_due.size() == 0)
                            void'(tick_feed.pop_front());
                    end
                    default: ;
                endcase
            end
            feed_done = (tick_feed.size() == 0) && !nxt_valid;
            s_valid <= nxt_valid;
            s_data <= nxt_data;
            cfg_wr <= nxt_wr;
            cfg_data <= nxt_wdata;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [tck_pkg::MS_W-1:0] want;
        int                       third;
        int                       stall_pct;
        if (i_rst_n) begin
            third = total_samples / 3;
            stall_pct = (samples_sent < third) ? 84 : (samples_sent < 2 * third) ? 27 : 0;
            if (o_m_axis_tvalid && m_ready) begin
                if (ms_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: elapsed_ms expected none got %0d", $time, o_m_axis_tdata);
                end else begin
                    want = ms_due.pop_front();
                    results_seen++;
                    if (o_m_axis_tdata !== want) begin
                        mismatch_count++;
                        $display("%0t: elapsed_ms expected %0d got %0d",
                                 $time, want, o_m_axis_tdata);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [tck_pkg::TICK_W-1:0] clock_now;
        logic [tck_pkg::TICK_W-1:0] step;
        logic [tck_pkg::MS_W-1:0]   seg_rate;
        int                         seg_left;
        int                         made;

        // default rate, carry of leftover ticks, huge and wrapped spans, then rates of one, zero, all ones and 1000
        queue_sample(64'd0);
        queue_sample(64'd99999);
        queue_sample(64'd100000);
        queue_sample(64'd250000);
        queue_sample(64'hFFFF_FFFF_FFFF_FFFF);
        queue_sample(64'd5);
        queue_drain();
        queue_rate(32'd1);
        queue_sample(64'h0000_0001_0000_0005);
        queue_sample(64'h5555_5555_5555_5555);
        queue_sample(64'hAAAA_AAAA_AAAA_AAAA);
        queue_rate(32'd0);
        queue_sample(64'h1234_5678_9ABC_DEF0);
        queue_sample(64'd0);
        queue_sample(64'hFFFF_FFFF_FFFF_FFFF);
        queue_rate(32'hFFFF_FFFF);
        queue_sample(64'd0);
        queue_sample(64'hFFFF_FFFF_FFFF_FFFF);
        queue_sample(64'h0000_0000_FFFF_FFFE);
        queue_rate(32'd1000);
        queue_sample(64'd1000);
        queue_sample(64'd1999);
        queue_sample(64'd2000);
        queue_sample(64'h8000_0000_0000_0000);
        queue_drain();

        // mostly a forward-running counter, with noise and jumps, over segments of random rates
        clock_now = {$urandom, $urandom};
        seg_rate = 32'd1000;
        seg_left = 0;
        made = 0;
        while (made < RANDOM_SAMPLES) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(30, 80);
                case ($urandom_range(0, 9))
                    0: seg_rate = 32'd1;
                    1: seg_rate = 32'hFFFF_FFFF;
                    2: seg_rate = 32'd0;
                    3: seg_rate = $urandom_range(2, 1000);
                    4, 5: seg_rate = $urandom_range(1000, 1000000);
                    6: seg_rate = $urandom;
                    default: seg_rate = tck_pkg::TICKS_PER_MS_RESET;
                endcase
                queue_rate(seg_rate);
            end
            case ($urandom_range(0, 19))
                0: queue_sample({$urandom, $urandom});
                1: begin
                    clock_now = clock_now + {30'd0, 2'($urandom_range(0, 3)), $urandom};
                    queue_sample(clock_now);
                end
                2: queue_sample(clock_now - $urandom_range(1, 1000));
                default: begin
                    step = 64'($urandom_range(0, 6)) * 64'(seg_rate);
                    if (seg_rate > 1)
                        step = step + 64'($urandom_range(0, seg_rate - 1));
                    else if (seg_rate == 0)
                        step = 64'($urandom);
                    clock_now = clock_now + step;
                    queue_sample(clock_now);
                end
            endcase
            if ($urandom_range(0, 49) == 0)
                queue_drain();
            seg_left--;
            made++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(feed_done && ms_due.size() == 0))
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("run covered %0d tick samples and %0d checked results", samples_sent,
                 results_seen);
        $display("ticks_per_ms written %0d times, including zero, one and all ones",
                 rate_writes);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tck_pkg.sv
hw/rtl/tck_div.sv
hw/rtl/tick_to_millisecond_converter_top.sv
dv/testbench.sv
